### hw/rtl/vstat_pkg.sv
package vstat_pkg;

   localparam int SAMPLE_W = 32;
   localparam int MEAN_W   = 40;
   localparam int COUNT_W  = 7;

   typedef enum logic [2:0] {
      T_LOAD  = 3'b001,
      T_START = 3'b010,
      T_WAIT  = 3'b100
   } top_state_type;

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_CAND  = 5'b00010,
      S_GRAB  = 5'b00100,
      S_SCAN  = 5'b01000,
      S_JUDGE = 5'b10000
   } sel_state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

### hw/rtl/vector_statistics_top.sv
// vector statistics: max, min, count, mean and upper median of a set of samples
//
// req channel: one signed sample per transaction, req_last closes the set.
// while a set is loading, one sample is taken every cycle and written to the
// sample store; running max, min and sum are updated on the fly. samples past
// MAX_ITEMS are dropped and raise rsp_overflowed.
// after the closing transaction req_stall stays high while the mean divider
// and the median search run side by side:
//   divider: restoring division, one quotient bit a cycle
//   median:  one compare per cycle through the single read port of the
//            sample store
// when both are done, the result goes out as one rsp transaction.
// rsp fields sit in an output register; the next set may load while a result
// is still stalled, and a finished set waits in place until that register frees.
// reset (synchronous, active high) empties the set and drops any pending rsp;
// the sample store is not cleared, only entries of the current set are read.
module vector_statistics_top #(
   parameter int MAX_ITEMS = 64,
   parameter int FRAC_BITS = 8
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [vstat_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                                  req_last,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_maximum,
   output logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_minimum,
   output logic signed [vstat_pkg::MEAN_W-1:0]   rsp_mean_fixed,
   output logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_median,
   output logic [vstat_pkg::COUNT_W-1:0]         rsp_sample_count,
   output logic                                  rsp_overflowed
);
   import vstat_pkg::*;

   localparam int CNT_W    = $clog2(MAX_ITEMS + 1);
   localparam int ADDR_W   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
   localparam int SUM_W    = SAMPLE_W + $clog2(MAX_ITEMS);
   localparam int SCALED_W = SUM_W + FRAC_BITS;

   top_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           kept_ff, kept_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       drop_ff, drop_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_max_ff, rsp_max_in;
   logic signed [SAMPLE_W-1:0] rsp_min_ff, rsp_min_in;
   logic signed [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic signed [SAMPLE_W-1:0] rsp_median_ff, rsp_median_in;
   logic [COUNT_W-1:0]         rsp_count_ff, rsp_count_in;
   logic                       rsp_drop_ff, rsp_drop_in;

   logic                       accept;
   logic                       room;
   logic                       wr_en;
   logic                       unit_start;
   logic                       out_free;
   logic                       results_ready;
   logic [ADDR_W-1:0]          rd_addr;
   logic [SAMPLE_W-1:0]        rd_data;
   unit_status_type            div_status;
   unit_status_type            sel_status;
   logic signed [SCALED_W-1:0] quotient;
   logic signed [SAMPLE_W-1:0] median;
   logic [CNT_W+COUNT_W-1:0]   count_ext;
   logic [SCALED_W+MEAN_W-1:0] mean_ext;

   assign req_stall     = (state_ff != T_LOAD);
   assign accept        = req_valid && !req_stall;
   assign room          = kept_ff < CNT_W'(MAX_ITEMS);
   assign wr_en         = accept && room;
   assign unit_start    = (state_ff == T_START);
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign results_ready = (state_ff == T_WAIT)
                          && div_status.done && !div_status.busy
                          && sel_status.done && !sel_status.busy;
   assign count_ext     = {{COUNT_W{1'b0}}, kept_ff};
   assign mean_ext      = {{MEAN_W{quotient[SCALED_W-1]}}, quotient};

   vstat_store #(
      .DEPTH  (MAX_ITEMS),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (kept_ff[ADDR_W-1:0]),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   vstat_divider #(
      .SUM_W     (SUM_W),
      .CNT_W     (CNT_W),
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (unit_start),
      .dividend (sum_ff),
      .divisor  (kept_ff),
      .status   (div_status),
      .quotient (quotient)
   );

   vstat_select #(
      .CNT_W  (CNT_W),
      .ADDR_W (ADDR_W)
   ) u_select (
      .clock   (clock),
      .reset   (reset),
      .start   (unit_start),
      .count   (kept_ff),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (sel_status),
      .median  (median)
   );

   always_comb begin
      state_in      = state_ff;
      kept_in       = kept_ff;
      max_in        = max_ff;
      min_in        = min_ff;
      sum_in        = sum_ff;
      drop_in       = drop_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_max_in    = rsp_max_ff;
      rsp_min_in    = rsp_min_ff;
      rsp_mean_in   = rsp_mean_ff;
      rsp_median_in = rsp_median_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_drop_in   = rsp_drop_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         T_LOAD: begin
            if (accept) begin
               if (room) begin
                  kept_in = kept_ff + CNT_W'(1);
                  sum_in  = sum_ff + SUM_W'(req_sample_value);
                  if (kept_ff == '0) begin
                     max_in = req_sample_value;
                     min_in = req_sample_value;
                  end else begin
                     if (req_sample_value > max_ff) begin
                        max_in = req_sample_value;
                     end
                     if (req_sample_value < min_ff) begin
                        min_in = req_sample_value;
                     end
                  end
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  state_in = T_START;
               end
            end
         end
         T_START: begin
            state_in = T_WAIT;
         end
         T_WAIT: begin
            if (results_ready && out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_max_in    = max_ff;
               rsp_min_in    = min_ff;
               rsp_mean_in   = mean_ext[MEAN_W-1:0];
               rsp_median_in = median;
               rsp_count_in  = count_ext[COUNT_W-1:0];
               rsp_drop_in   = drop_ff;
               kept_in       = '0;
               max_in        = '0;
               min_in        = '0;
               sum_in        = '0;
               drop_in       = 1'b0;
               state_in      = T_LOAD;
            end
         end
         default: begin
            state_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         kept_ff      <= '0;
         max_ff       <= '0;
         min_ff       <= '0;
         sum_ff       <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kept_ff      <= kept_in;
         max_ff       <= max_in;
         min_ff       <= min_in;
         sum_ff       <= sum_in;
         drop_ff      <= drop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_max_ff    <= rsp_max_in;
      rsp_min_ff    <= rsp_min_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_median_ff <= rsp_median_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_drop_ff   <= rsp_drop_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_maximum      = rsp_max_ff;
   assign rsp_minimum      = rsp_min_ff;
   assign rsp_mean_fixed   = rsp_mean_ff;
   assign rsp_median       = rsp_median_ff;
   assign rsp_sample_count = rsp_count_ff;
   assign rsp_overflowed   = rsp_drop_ff;

endmodule

### hw/rtl/vstat_store.sv
module vstat_store #(
   parameter int DEPTH  = 64,
   parameter int ADDR_W = 6
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [ADDR_W-1:0]              wr_addr,
   input  logic [vstat_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]              rd_addr,
   output logic [vstat_pkg::SAMPLE_W-1:0] rd_data
);
   import vstat_pkg::*;

   logic [SAMPLE_W-1:0] mem_ff [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/vstat_divider.sv
module vstat_divider #(
   parameter int SUM_W     = 38,
   parameter int CNT_W     = 7,
   parameter int FRAC_BITS = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [SUM_W-1:0]           dividend,
   input  logic [CNT_W-1:0]                  divisor,
   output vstat_pkg::unit_status_type        status,
   output logic signed [SUM_W+FRAC_BITS-1:0] quotient
);
   import vstat_pkg::*;

   localparam int SCALED_W = SUM_W + FRAC_BITS;
   localparam int STEP_W   = $clog2(SCALED_W + 1);

   logic [SCALED_W-1:0] dvd_ff, dvd_in;
   logic [CNT_W:0]      rem_ff, rem_in;
   logic [CNT_W-1:0]    den_ff, den_in;
   logic                sign_ff, sign_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;

   logic [SUM_W-1:0]    sum_mag;
   logic [CNT_W:0]      shifted;
   logic                fits;

   // magnitude of the sum; the most negative value maps to its unsigned magnitude
   assign sum_mag = dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
   assign shifted = {rem_ff[CNT_W-1:0], dvd_ff[SCALED_W-1]};
   assign fits    = shifted >= {1'b0, den_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      sign_in = sign_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvd_in  = SCALED_W'(sum_mag) << FRAC_BITS;
         rem_in  = '0;
         den_in  = divisor;
         sign_in = dividend[SUM_W-1];
         step_in = STEP_W'(SCALED_W);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         // one restoring step per cycle, quotient bits shift in at the bottom
         rem_in  = fits ? (shifted - {1'b0, den_ff}) : shifted;
         dvd_in  = {dvd_ff[SCALED_W-2:0], fits};
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff  <= dvd_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      sign_ff <= sign_in;
   end

   assign quotient    = sign_ff ? (~dvd_ff + SCALED_W'(1)) : dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

### hw/rtl/vstat_select.sv
module vstat_select #(
   parameter int CNT_W  = 7,
   parameter int ADDR_W = 6
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic [CNT_W-1:0]                      count,
   output logic [ADDR_W-1:0]                     rd_addr,
   input  logic [vstat_pkg::SAMPLE_W-1:0]        rd_data,
   output vstat_pkg::unit_status_type            status,
   output logic signed [vstat_pkg::SAMPLE_W-1:0] median
);
   import vstat_pkg::*;

   sel_state_type              state_ff, state_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [CNT_W-1:0]           cand_idx_ff, cand_idx_in;
   logic [CNT_W-1:0]           scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]           less_ff, less_in;
   logic [CNT_W-1:0]           equal_ff, equal_in;
   logic signed [SAMPLE_W-1:0] cand_ff, cand_in;
   logic signed [SAMPLE_W-1:0] median_ff, median_in;
   logic                       done_ff, done_in;

   logic signed [SAMPLE_W-1:0] element;
   logic [CNT_W-1:0]           rank;
   logic                       found;

   assign element = $signed(rd_data);
   assign rank    = n_ff >> 1;
   // candidate sits at the target rank when its run of equal values covers it
   assign found   = (less_ff <= rank) && (rank < (less_ff + equal_ff));

   always_comb begin
      state_in    = state_ff;
      n_in        = n_ff;
      cand_idx_in = cand_idx_ff;
      scan_idx_in = scan_idx_ff;
      less_in     = less_ff;
      equal_in    = equal_ff;
      cand_in     = cand_ff;
      median_in   = median_ff;
      done_in     = done_ff;
      rd_addr     = cand_idx_ff[ADDR_W-1:0];
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in        = count;
               cand_idx_in = '0;
               done_in     = 1'b0;
               state_in    = S_CAND;
            end
         end
         S_CAND: begin
            rd_addr  = cand_idx_ff[ADDR_W-1:0];
            state_in = S_GRAB;
         end
         S_GRAB: begin
            cand_in     = element;
            rd_addr     = '0;
            scan_idx_in = CNT_W'(1);
            less_in     = '0;
            equal_in    = '0;
            state_in    = S_SCAN;
         end
         S_SCAN: begin
            rd_addr     = scan_idx_ff[ADDR_W-1:0];
            scan_idx_in = scan_idx_ff + CNT_W'(1);
            if (element < cand_ff) begin
               less_in = less_ff + CNT_W'(1);
            end
            if (element == cand_ff) begin
               equal_in = equal_ff + CNT_W'(1);
            end
            if (scan_idx_ff == n_ff) begin
               state_in = S_JUDGE;
            end
         end
         S_JUDGE: begin
            if (found) begin
               median_in = cand_ff;
               done_in   = 1'b1;
               state_in  = S_IDLE;
            end else begin
               cand_idx_in = cand_idx_ff + CNT_W'(1);
               state_in    = S_CAND;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      n_ff        <= n_in;
      cand_idx_ff <= cand_idx_in;
      scan_idx_ff <= scan_idx_in;
      less_ff     <= less_in;
      equal_ff    <= equal_in;
      cand_ff     <= cand_in;
      median_ff   <= median_in;
   end

   assign median      = median_ff;
   assign status.busy = (state_ff != S_IDLE);
   assign status.done = done_ff;

endmodule

### tb/tb_vector_statistics_top.sv
`timescale 1ns / 1ps

typedef struct {
   logic signed [vstat_pkg::SAMPLE_W-1:0] maximum;
   logic signed [vstat_pkg::SAMPLE_W-1:0] minimum;
   logic signed [vstat_pkg::MEAN_W-1:0]   mean_fixed;
   logic signed [vstat_pkg::SAMPLE_W-1:0] median;
   logic [vstat_pkg::COUNT_W-1:0]         sample_count;
   logic                                  overflowed;
} set_stats_type;

class stats_scoreboard #(int DEPTH = 64, int FRAC = 8);
   logic signed [vstat_pkg::SAMPLE_W-1:0] store [DEPTH];
   int                                    kept;
   logic signed [vstat_pkg::SAMPLE_W-1:0] run_max;
   logic signed [vstat_pkg::SAMPLE_W-1:0] run_min;
   longint                                run_sum;
   bit                                    dropped;
   set_stats_type                         expected_stats [$];
   int                                    mismatches;

   function new();
      mismatches = 0;
      clear_set();
   endfunction

   function void clear_set();
      kept    = 0;
      run_max = '0;
      run_min = '0;
      run_sum = 0;
      dropped = 1'b0;
   endfunction

   // running max/min/sum per sample, full statistics on the closing sample
   function void take_sample(logic signed [vstat_pkg::SAMPLE_W-1:0] value, logic last);
      set_stats_type                         s;
      logic signed [vstat_pkg::SAMPLE_W-1:0] sorted [DEPTH];
      logic signed [vstat_pkg::SAMPLE_W-1:0] x;
      longint                                scaled;
      int                                    i;
      int                                    j;
      if (kept < DEPTH) begin
         store[kept] = value;
         if (kept == 0) begin
            run_max = value;
            run_min = value;
         end else begin
            if (value > run_max) run_max = value;
            if (value < run_min) run_min = value;
         end
         run_sum += longint'(value);
         kept++;
      end else begin
         dropped = 1'b1;
      end
      if (!last) return;
      for (i = 0; i < kept; i++) begin
         x = store[i];
         j = i;
         while (j > 0 && sorted[j-1] > x) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = x;
      end
      scaled         = run_sum * (longint'(1) << FRAC);
      s.maximum      = run_max;
      s.minimum      = run_min;
      s.mean_fixed   = vstat_pkg::MEAN_W'(scaled / longint'(kept));
      s.median       = sorted[kept / 2];
      s.sample_count = vstat_pkg::COUNT_W'(kept);
      s.overflowed   = dropped;
      expected_stats.push_back(s);
      clear_set();
   endfunction

   function void compare_field(string name, logic signed [63:0] want, logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         mismatches++;
      end
   endfunction

   function void check_stats(set_stats_type got);
      set_stats_type want;
      if (expected_stats.size() == 0) begin
         $error("rsp transaction with no set closed");
         mismatches++;
         return;
      end
      want = expected_stats.pop_front();
      compare_field("maximum", want.maximum, got.maximum);
      compare_field("minimum", want.minimum, got.minimum);
      compare_field("mean_fixed", want.mean_fixed, got.mean_fixed);
      compare_field("median", want.median, got.median);
      compare_field("sample_count", {1'b0, want.sample_count}, {1'b0, got.sample_count});
      compare_field("overflowed", {1'b0, want.overflowed}, {1'b0, got.overflowed});
   endfunction
endclass

module tb_vector_statistics_top;

   localparam int DEPTH          = 64;
   localparam int FRAC           = 8;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int TAIL_ITEMS     = 150;
   localparam int WATCHDOG_LIMIT = 30000;

   typedef enum int {
      VAL_FULL,
      VAL_NARROW,
      VAL_EDGE,
      VAL_MID
   } value_mode_type;

   logic                                  clock;
   logic                                  reset;
   logic                                  req_valid;
   logic                                  req_stall;
   logic signed [vstat_pkg::SAMPLE_W-1:0] req_sample_value;
   logic                                  req_last;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_maximum;
   logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_minimum;
   logic signed [vstat_pkg::MEAN_W-1:0]   rsp_mean_fixed;
   logic signed [vstat_pkg::SAMPLE_W-1:0] rsp_median;
   logic [vstat_pkg::COUNT_W-1:0]         rsp_sample_count;
   logic                                  rsp_overflowed;

   stats_scoreboard #(DEPTH, FRAC) sb;
   bit idle_enable;
   int items_sent;
   int quiet_cycles;

   vector_statistics_top #(
      .MAX_ITEMS (DEPTH),
      .FRAC_BITS (FRAC)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample_value (req_sample_value),
      .req_last         (req_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_maximum      (rsp_maximum),
      .rsp_minimum      (rsp_minimum),
      .rsp_mean_fixed   (rsp_mean_fixed),
      .rsp_median       (rsp_median),
      .rsp_sample_count (rsp_sample_count),
      .rsp_overflowed   (rsp_overflowed)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin : rsp_stall_gen
      int burst;
      burst     = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (burst > 0) begin
            rsp_stall = 1'b1;
            burst--;
         end else begin
            rsp_stall = 1'b0;
            if (idle_enable && $urandom_range(0, 5) == 0) burst = $urandom_range(1, 7);
         end
      end
   end

   always @(posedge clock) begin : monitor
      set_stats_type got;
      bit            moved;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         if (req_valid && !req_stall) begin
            sb.take_sample(req_sample_value, req_last);
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got.maximum      = rsp_maximum;
            got.minimum      = rsp_minimum;
            got.mean_fixed   = rsp_mean_fixed;
            got.median       = rsp_median;
            got.sample_count = rsp_sample_count;
            got.overflowed   = rsp_overflowed;
            sb.check_stats(got);
            moved = 1'b1;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_vector_statistics_top: FAIL");
            $finish;
         end
      end
   end

   task automatic send_sample(input logic signed [vstat_pkg::SAMPLE_W-1:0] value,
                              input logic last);
      int gap;
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 7);
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid        = 1'b1;
      req_sample_value = value;
      req_last         = last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   // hold off until every closed set has been answered
   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (sb.expected_stats.size() != 0) @(negedge clock);
   endtask

   function automatic logic signed [vstat_pkg::SAMPLE_W-1:0] sample_for_mode(
      value_mode_type mode);
      logic signed [vstat_pkg::SAMPLE_W-1:0] v;
      case (mode)
         VAL_NARROW: v = $signed($urandom_range(0, 15)) - 8;
         VAL_MID:    v = $signed($urandom_range(0, 2000)) - 1000;
         VAL_EDGE: begin
            case ($urandom_range(0, 4))
               0:       v = 32'h7fffffff;
               1:       v = 32'h80000000;
               2:       v = 32'h00000000;
               3:       v = 32'hffffffff;
               default: v = 32'h00000001;
            endcase
         end
         default:    v = $urandom;
      endcase
      return v;
   endfunction

   task automatic send_set(int len, value_mode_type mode);
      int i;
      for (i = 0; i < len; i++) send_sample(sample_for_mode(mode), i == len - 1);
   endtask

   initial begin : stimulus
      int             start;
      int             len;
      int             pick;
      int             i;
      value_mode_type mode;
      sb               = new();
      idle_enable      = 1'b0;
      items_sent       = 0;
      quiet_cycles     = 0;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      req_last         = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_enable = 1'b1;
      // single-sample sets at the extremes and at zero
      send_sample(32'h7fffffff, 1'b1);
      send_sample(32'h80000000, 1'b1);
      send_sample(32'h00000000, 1'b1);
      // negative fractional means truncate toward zero
      send_sample(32'h7fffffff, 1'b0);
      send_sample(32'h80000000, 1'b1);
      send_sample(-1, 1'b0);
      send_sample(-2, 1'b0);
      send_sample(-2, 1'b1);
      // even count, duplicates, upper median; then two odd-count sets
      send_sample(5, 1'b0);
      send_sample(5, 1'b0);
      send_sample(3, 1'b0);
      send_sample(3, 1'b1);
      send_sample(1, 1'b0);
      send_sample(-1, 1'b0);
      send_sample(32'h55555555, 1'b0);
      send_sample(32'haaaaaaaa, 1'b0);
      send_sample(7, 1'b1);
      send_sample(3, 1'b0);
      send_sample(1, 1'b0);
      send_sample(2, 1'b1);
      // store exactly full, then full with last on a dropped sample
      for (i = 0; i < DEPTH; i++) send_sample(32'h7fffffff, i == DEPTH - 1);
      for (i = 0; i < DEPTH + 2; i++) send_sample(32'h80000000, i == DEPTH + 1);
      drain_results();

      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         if (items_sent - start >= RANDOM_ITEMS - TAIL_ITEMS) idle_enable = 1'b0;
         else idle_enable = ($urandom_range(0, 3) != 0);
         pick = $urandom_range(0, 99);
         if (pick < 60)      len = $urandom_range(1, 8);
         else if (pick < 88) len = $urandom_range(9, 32);
         else if (pick < 95) len = $urandom_range(33, DEPTH - 1);
         else                len = $urandom_range(DEPTH, DEPTH + 6);
         mode = value_mode_type'($urandom_range(0, 3));
         send_set(len, mode);
         if (idle_enable && $urandom_range(0, 29) == 0) drain_results();
      end

      idle_enable = 1'b0;
      drain_results();
      repeat (64) @(negedge clock);
      if (sb.mismatches == 0 && sb.expected_stats.size() == 0) begin
         $display("tb_vector_statistics_top: PASS");
      end else begin
         $display("tb_vector_statistics_top: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/vstat_pkg.sv
hw/rtl/vstat_store.sv
hw/rtl/vstat_divider.sv
hw/rtl/vstat_select.sv
hw/rtl/vector_statistics_top.sv
tb/tb_vector_statistics_top.sv
